// ----- design/dual_laser_scan_to_world_points_assert.svh -----
// Assertion macros for the scan-to-world top level
`ifndef DUAL_LASER_SCAN_TO_WORLD_POINTS_ASSERT_SVH
`define DUAL_LASER_SCAN_TO_WORLD_POINTS_ASSERT_SVH

// Same-cycle implication, sampled on clk, held off during reset
`define DLSW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, held off during reset
`define DLSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/dlsw_pkg.sv -----
// Types, constants and helper functions for the scan-to-world pipeline
`default_nettype none
package dlsw_pkg;

  localparam int MAX_BEAMS    = 1024;
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam int PIPE_LEN     = CORDIC_LAT + 3;
  localparam int CW           = 34;
  localparam int ZW           = 33;
  localparam int PADDR_W      = 5;

  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] EIGHTH_TURN  = 32'h2000_0000;

  localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
    30'd536870912, 30'd316933405, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335086,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41721, 30'd20860,
    30'd10430, 30'd5215, 30'd2607, 30'd1303, 30'd651, 30'd325, 30'd162,
    30'd81, 30'd40, 30'd20, 30'd10, 30'd5, 30'd2, 30'd1
  };

  typedef enum logic [2:0] {
    REG_MOUNT_FWD   = 3'd0,
    REG_MOUNT_SIDE  = 3'd1,
    REG_RIGHT_ROT   = 3'd2,
    REG_BEAM_STEP   = 3'd3,
    REG_RANGE_SCALE = 3'd4,
    REG_VALID_THR   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic        [9:0]  beam_index;
    logic        [15:0] left_range;
    logic        [15:0] right_range;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic        [31:0] heading;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] left_point_x;
    logic signed [31:0] left_point_y;
    logic               left_valid;
    logic signed [31:0] right_point_x;
    logic signed [31:0] right_point_y;
    logic               right_valid;
  } out_beat_t;

  typedef struct packed {
    logic left_ok;
    logic right_ok;
  } hit_flags_t;

  // Round half up from Q46 to Q16.16 (floor shift)
  function automatic logic signed [CW-1:0] rnd30(input logic signed [66:0] v);
    logic signed [66:0] t;
    t = (v + 67'sd536870912) >>> 30;
    return t[CW-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7fff_ffff;
    else if (v < -36'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/dlsw_if.sv -----
// Valid/ready stream interfaces for beam beats and world point beats
`default_nettype none
interface dlsw_in_if;
  import dlsw_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface dlsw_out_if;
  import dlsw_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- design/dual_laser_scan_to_world_points.sv -----
// Top level: dual laser scan beats to world points, with APB register file
`default_nettype none
`include "dual_laser_scan_to_world_points_assert.svh"
// Takes one beat per clock carrying a beam index, a left and a right raw
// range and the vehicle pose, and returns one beat with the world position
// of both beam hits in Q16.16 metres, saturated, plus a valid flag for each
// (range above the threshold and index inside the scan). The accepting edge
// loads the beam angle and range scaling; then come the pipelined CORDIC
// units (one for the heading, one per scanner lane, all side by side), the
// projection multipliers in the lanes beside the mount multipliers in the
// merge, then the merge and output register. Throughput is one beat per
// cycle; the whole pipeline holds while a result waits on out_pt, so
// in_beam.ready follows out_pt.ready when a result is pending, and stays
// low during reset.
// Registers sit at byte address 4*index on the APB port and must only be
// written while no beat is in flight.
module dual_laser_scan_to_world_points (
  input  logic                         clk,
  input  logic                         rst_n,
  dlsw_in_if.sink                      in_beam,
  dlsw_out_if.source                   out_pt,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dlsw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import dlsw_pkg::*;

  // Register file
  logic signed [31:0] mount_fwd_r, mount_side_r;
  logic [31:0]        right_rot_r, beam_step_r, range_scale_r;
  logic [15:0]        thr_r;
  reg_idx_t           reg_sel;

  // Pipeline control
  logic                advance;
  logic                in_fire;
  logic [PIPE_LEN-1:0] vld_r, vld_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Front stage
  logic [41:0]        step_prod;
  logic [31:0]        beam_ang;
  logic [47:0]        dl_full, dr_full;
  logic               in_scan;
  hit_flags_t         flags_in;
  logic [31:0]        ang_h_r, ang_l_r, ang_r_r, dl_r, dr_r;
  logic signed [31:0] px_r [CORDIC_LAT+1];
  logic signed [31:0] py_r [CORDIC_LAT+1];
  hit_flags_t         fl_r [CORDIC_LAT+1];

  logic signed [CW-1:0] hc, hs, lpx, lpy, rpx, rpy;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mount_fwd_r   <= '0;
      mount_side_r  <= '0;
      right_rot_r   <= '0;
      beam_step_r   <= 32'd5965232;
      range_scale_r <= 32'd4294967;
      thr_r         <= 16'd20;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_MOUNT_FWD:   mount_fwd_r   <= pwdata;
        REG_MOUNT_SIDE:  mount_side_r  <= pwdata;
        REG_RIGHT_ROT:   right_rot_r   <= pwdata;
        REG_BEAM_STEP:   beam_step_r   <= pwdata;
        REG_RANGE_SCALE: range_scale_r <= pwdata;
        REG_VALID_THR:   thr_r         <= pwdata[15:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MOUNT_FWD:   prdata = mount_fwd_r;
      REG_MOUNT_SIDE:  prdata = mount_side_r;
      REG_RIGHT_ROT:   prdata = right_rot_r;
      REG_BEAM_STEP:   prdata = beam_step_r;
      REG_RANGE_SCALE: prdata = range_scale_r;
      REG_VALID_THR:   prdata = {16'd0, thr_r};
      default:         prdata = '0;
    endcase
  end

  // Whole pipeline advances unless a finished beat is stuck at the output
  assign advance         = !out_valid_r || out_pt.ready;
  assign in_beam.ready   = advance && rst_n;
  assign in_fire         = in_beam.valid && advance;
  assign vld_nxt         = advance ? {vld_r[PIPE_LEN-2:0], in_fire} : vld_r;
  assign out_valid_nxt   = advance ? vld_r[PIPE_LEN-1] : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_pt.valid = out_valid_r;

  // Beam angle: heading - index * step + quarter turn, wrapping
  assign step_prod = 42'(in_beam.data.beam_index) * 42'(beam_step_r);
  assign beam_ang  = in_beam.data.heading - step_prod[31:0] + QUARTER_TURN;
  // Range to Q16.16 metres, rounded
  assign dl_full   = 48'(in_beam.data.left_range) * 48'(range_scale_r) + 48'h8000;
  assign dr_full   = 48'(in_beam.data.right_range) * 48'(range_scale_r) + 48'h8000;
  assign in_scan   = 32'(in_beam.data.beam_index) < 32'(MAX_BEAMS);
  assign flags_in.left_ok  = in_scan && (in_beam.data.left_range > thr_r);
  assign flags_in.right_ok = in_scan && (in_beam.data.right_range > thr_r);

  always_ff @(posedge clk) begin
    if (advance) begin
      ang_h_r <= in_beam.data.heading;
      ang_l_r <= beam_ang;
      ang_r_r <= beam_ang + right_rot_r;
      dl_r    <= dl_full[47:16];
      dr_r    <= dr_full[47:16];
      px_r[0] <= in_beam.data.pose_x;
      py_r[0] <= in_beam.data.pose_y;
      fl_r[0] <= flags_in;
      // Hold pose and flags level with the CORDIC units
      for (int k = 1; k <= CORDIC_LAT; k++) begin
        px_r[k] <= px_r[k-1];
        py_r[k] <= py_r[k-1];
        fl_r[k] <= fl_r[k-1];
      end
    end
  end

  dlsw_cordic u_head (
    .clk   (clk),
    .en    (advance),
    .ang   (ang_h_r),
    .cos_o (hc),
    .sin_o (hs)
  );

  dlsw_lane u_left (
    .clk       (clk),
    .en        (advance),
    .ang       (ang_l_r),
    .beam_dist (dl_r),
    .proj_x    (lpx),
    .proj_y    (lpy)
  );

  dlsw_lane u_right (
    .clk       (clk),
    .en        (advance),
    .ang       (ang_r_r),
    .beam_dist (dr_r),
    .proj_x    (rpx),
    .proj_y    (rpy)
  );

  dlsw_merge u_merge (
    .clk        (clk),
    .en         (advance),
    .pose_x     (px_r[CORDIC_LAT]),
    .pose_y     (py_r[CORDIC_LAT]),
    .flags      (fl_r[CORDIC_LAT]),
    .hc         (hc),
    .hs         (hs),
    .mount_fwd  (mount_fwd_r),
    .mount_side (mount_side_r),
    .lpx        (lpx),
    .lpy        (lpy),
    .rpx        (rpx),
    .rpy        (rpy),
    .beat       (out_pt.data)
  );

  `DLSW_ASSERT_NOW(a_stall_blocks_input, out_valid_r && !out_pt.ready, !in_beam.ready, "input taken while output stalled")
  `DLSW_ASSERT_NOW(a_out_from_pipe, $rose(out_valid_r), $past(vld_r[PIPE_LEN-1]), "result without a beat in the last stage")
  `DLSW_ASSERT_NEXT(a_thr_write, psel && penable && pwrite && (reg_sel == REG_VALID_THR), thr_r == $past(pwdata[15:0]), "threshold write lost")

endmodule
`default_nettype wire

// ----- design/dlsw_cordic.sv -----
// Fully pipelined rotation CORDIC giving Q2.30 cosine and sine of a binary angle
`default_nettype none
module dlsw_cordic (
  input  logic                          clk,
  input  logic                          en,
  input  logic [31:0]                   ang,
  output logic signed [dlsw_pkg::CW-1:0] cos_o,
  output logic signed [dlsw_pkg::CW-1:0] sin_o
);
  import dlsw_pkg::*;

  logic signed [CW-1:0] x_r [CORDIC_STEPS+1];
  logic signed [CW-1:0] y_r [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_r [CORDIC_STEPS+1];
  logic [1:0]           q_r [CORDIC_STEPS+1];
  logic [31:0]          rnd_ang;
  logic [31:0]          resid;

  // Fold to the nearest quarter turn
  assign rnd_ang = ang + EIGHTH_TURN;
  assign resid   = ang - {rnd_ang[31:30], 30'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_X0;
      y_r[0] <= '0;
      z_r[0] <= $signed({resid[31], resid});
      q_r[0] <= rnd_ang[31:30];
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - $signed({3'b000, ATAN_TAB[i]});
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + $signed({3'b000, ATAN_TAB[i]});
        end
        q_r[i+1] <= q_r[i];
      end
    end
  end

  // Unfold by quadrant
  always_ff @(posedge clk) begin
    if (en) begin
      case (q_r[CORDIC_STEPS])
        2'd0: begin
          cos_o <= x_r[CORDIC_STEPS];
          sin_o <= y_r[CORDIC_STEPS];
        end
        2'd1: begin
          cos_o <= -y_r[CORDIC_STEPS];
          sin_o <= x_r[CORDIC_STEPS];
        end
        2'd2: begin
          cos_o <= -x_r[CORDIC_STEPS];
          sin_o <= -y_r[CORDIC_STEPS];
        end
        default: begin
          cos_o <= y_r[CORDIC_STEPS];
          sin_o <= -x_r[CORDIC_STEPS];
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/dlsw_lane.sv -----
// One scanner lane: beam sine/cosine and projection of the scaled range
`default_nettype none
module dlsw_lane (
  input  logic                          clk,
  input  logic                          en,
  input  logic [31:0]                   ang,
  input  logic [31:0]                   beam_dist,
  output logic signed [dlsw_pkg::CW-1:0] proj_x,
  output logic signed [dlsw_pkg::CW-1:0] proj_y
);
  import dlsw_pkg::*;

  logic signed [CW-1:0] bc;
  logic signed [CW-1:0] bs;
  logic [31:0]          d_r [CORDIC_LAT];
  logic signed [66:0]   px_r;
  logic signed [66:0]   py_r;

  dlsw_cordic u_cordic (
    .clk   (clk),
    .en    (en),
    .ang   (ang),
    .cos_o (bc),
    .sin_o (bs)
  );

  // Hold the distance alongside the rotation
  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= beam_dist;
      for (int k = 1; k < CORDIC_LAT; k++) d_r[k] <= d_r[k-1];
      px_r   <= 67'($signed({1'b0, d_r[CORDIC_LAT-1]})) * 67'(bc);
      py_r   <= 67'($signed({1'b0, d_r[CORDIC_LAT-1]})) * 67'(bs);
      proj_x <= rnd30(px_r);
      proj_y <= rnd30(py_r);
    end
  end

endmodule
`default_nettype wire

// ----- design/dlsw_merge.sv -----
// Merge stage: mount offsets, pose and lane projections summed and saturated
`default_nettype none
module dlsw_merge (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [31:0]            pose_x,
  input  logic signed [31:0]            pose_y,
  input  dlsw_pkg::hit_flags_t          flags,
  input  logic signed [dlsw_pkg::CW-1:0] hc,
  input  logic signed [dlsw_pkg::CW-1:0] hs,
  input  logic signed [31:0]            mount_fwd,
  input  logic signed [31:0]            mount_side,
  input  logic signed [dlsw_pkg::CW-1:0] lpx,
  input  logic signed [dlsw_pkg::CW-1:0] lpy,
  input  logic signed [dlsw_pkg::CW-1:0] rpx,
  input  logic signed [dlsw_pkg::CW-1:0] rpy,
  output dlsw_pkg::out_beat_t           beat
);
  import dlsw_pkg::*;

  logic signed [65:0] fhc_r, shs_r, fhs_r, shc_r;
  logic signed [31:0] pxa_r, pya_r;
  hit_flags_t         fa_r, fb_r;
  logic signed [34:0] lmx_r, lmy_r, rmx_r, rmy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      fhc_r <= 66'(mount_fwd) * 66'(hc);
      shs_r <= 66'(mount_side) * 66'(hs);
      fhs_r <= 66'(mount_fwd) * 66'(hs);
      shc_r <= 66'(mount_side) * 66'(hc);
      pxa_r <= pose_x;
      pya_r <= pose_y;
      fa_r  <= flags;

      // Mount points: side offset added for left, subtracted for right
      lmx_r <= 35'(pxa_r) + 35'(rnd30(67'(fhc_r) - 67'(shs_r)));
      lmy_r <= 35'(pya_r) + 35'(rnd30(67'(fhs_r) + 67'(shc_r)));
      rmx_r <= 35'(pxa_r) + 35'(rnd30(67'(fhc_r) + 67'(shs_r)));
      rmy_r <= 35'(pya_r) + 35'(rnd30(67'(fhs_r) - 67'(shc_r)));
      fb_r  <= fa_r;

      beat.left_point_x  <= sat32(36'(lmx_r) + 36'(lpx));
      beat.left_point_y  <= sat32(36'(lmy_r) + 36'(lpy));
      beat.left_valid    <= fb_r.left_ok;
      beat.right_point_x <= sat32(36'(rmx_r) + 36'(rpx));
      beat.right_point_y <= sat32(36'(rmy_r) + 36'(rpy));
      beat.right_valid   <= fb_r.right_ok;
    end
  end

endmodule
`default_nettype wire

// ----- sim/dlsw_scoreboard.sv -----
// Scan-to-world checker: watches both streams and the APB port, predicts and compares
`timescale 1ns / 100ps
`default_nettype none
module dlsw_scoreboard
  import dlsw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  dlsw_in_if                  beams,
  dlsw_out_if                 points,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  output int                  fail_count,
  output int                  pending
);

  localparam longint CORDIC_GAIN = 64'sd652032874;
  localparam longint HALF_LSB_Q46 = 64'sd536870912;

  // Register shadow, reset values
  logic signed [31:0] fwd_q;
  logic signed [31:0] side_q;
  logic [31:0]        rrot_q;
  logic [31:0]        step_q;
  logic [31:0]        scale_q;
  logic [15:0]        thr_q;

  out_beat_t expected_points[$];

  function automatic longint round_q46(input longint v);
    return (v + HALF_LSB_Q46) >>> 30;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Quadrant fold then 30-step rotation CORDIC, results Q2.30
  task automatic sin_cos(input logic [31:0] ang, output longint c, output longint s);
    logic [31:0] quad;
    logic [31:0] resid;
    longint      x, y, z, t;
    quad  = ((ang + EIGHTH_TURN) >> 30) & 32'd3;
    resid = ang - (quad << 30);
    z = longint'(signed'(resid));
    x = CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(ATAN_TAB[i]);
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(ATAN_TAB[i]);
      end
      x = t;
    end
    case (quad[1:0])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  task automatic world_points(input in_beat_t b, output out_beat_t r);
    longint hc, hs, bc, bs, dl, dr, f, sd;
    longint lmx, lmy, rmx, rmy;
    logic [31:0] beam_ang;
    logic        in_scan;
    f  = longint'(fwd_q);
    sd = longint'(side_q);
    in_scan = int'(b.beam_index) < MAX_BEAMS;
    sin_cos(b.heading, hc, hs);
    lmx = longint'(b.pose_x) + round_q46(f * hc - sd * hs);
    lmy = longint'(b.pose_y) + round_q46(f * hs + sd * hc);
    rmx = longint'(b.pose_x) + round_q46(f * hc + sd * hs);
    rmy = longint'(b.pose_y) + round_q46(f * hs - sd * hc);
    beam_ang = b.heading - 32'(b.beam_index) * step_q + QUARTER_TURN;
    dl = longint'((64'(b.left_range) * 64'(scale_q) + 64'h8000) >> 16);
    dr = longint'((64'(b.right_range) * 64'(scale_q) + 64'h8000) >> 16);
    sin_cos(beam_ang, bc, bs);
    r.left_point_x = clamp32(lmx + round_q46(dl * bc));
    r.left_point_y = clamp32(lmy + round_q46(dl * bs));
    r.left_valid   = in_scan && (b.left_range > thr_q);
    sin_cos(beam_ang + rrot_q, bc, bs);
    r.right_point_x = clamp32(rmx + round_q46(dr * bc));
    r.right_point_y = clamp32(rmy + round_q46(dr * bs));
    r.right_valid   = in_scan && (b.right_range > thr_q);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t dlsw_scoreboard: %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = expected_points.size();

  always @(posedge clk) begin
    out_beat_t pred;
    out_beat_t want;
    out_beat_t got;
    if (!rst_n) begin
      fwd_q   <= '0;
      side_q  <= '0;
      rrot_q  <= '0;
      step_q  <= 32'd5965232;
      scale_q <= 32'd4294967;
      thr_q   <= 16'd20;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr >> 2)
          REG_MOUNT_FWD:   fwd_q   <= pwdata;
          REG_MOUNT_SIDE:  side_q  <= pwdata;
          REG_RIGHT_ROT:   rrot_q  <= pwdata;
          REG_BEAM_STEP:   step_q  <= pwdata;
          REG_RANGE_SCALE: scale_q <= pwdata;
          REG_VALID_THR:   thr_q   <= pwdata[15:0];
          default: ;
        endcase
      end
      if (beams.valid && beams.ready) begin
        world_points(beams.data, pred);
        expected_points.insert(expected_points.size(), pred);
      end
      if (points.valid && points.ready) begin
        got = points.data;
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected point beat, left_x", got.left_point_x, 0);
        end else begin
          want = expected_points.pop_front();
          if (got.left_point_x != want.left_point_x)
            report_mismatch("left_point_x", got.left_point_x, want.left_point_x);
          if (got.left_point_y != want.left_point_y)
            report_mismatch("left_point_y", got.left_point_y, want.left_point_y);
          if (got.left_valid !== want.left_valid)
            report_mismatch("left_valid", got.left_valid, want.left_valid);
          if (got.right_point_x != want.right_point_x)
            report_mismatch("right_point_x", got.right_point_x, want.right_point_x);
          if (got.right_point_y != want.right_point_y)
            report_mismatch("right_point_y", got.right_point_y, want.right_point_y);
          if (got.right_valid !== want.right_valid)
            report_mismatch("right_valid", got.right_valid, want.right_valid);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench top: clock, reset, APB set-up, beam stimulus and the verdict
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import dlsw_pkg::*;

  localparam int RST_CYCLES   = 6;
  localparam int DRAIN_CYCLES = 50;     // longer than the pipeline
  localparam int STALL_LIMIT  = 4000;
  localparam int N_PHASES     = 5;
  localparam int BEAMS_PER_PHASE = 320;
  localparam logic [2:0] UNMAPPED_REG = 3'd6;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  int send_gap_pct = 0;
  int sink_stall_pct = 0;
  int fail_count;
  int pending;
  int quiet_cycles = 0;

  dlsw_in_if  beam_ch ();
  dlsw_out_if point_ch ();

  always #1 clk = ~clk;

  dual_laser_scan_to_world_points u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_beam (beam_ch),
    .out_pt  (point_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  dlsw_scoreboard u_scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .beams      (beam_ch),
    .points     (point_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    beam_ch.valid  = 1'b0;
    beam_ch.data   = '0;
    point_ch.ready = 1'b1;
  end

  // Receiver side: stall at random, redrawn every falling edge
  always @(negedge clk) begin
    point_ch.ready = ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog: end the run if neither stream moves a beat for too long
  always @(posedge clk) begin
    if ((beam_ch.valid && beam_ch.ready) || (point_ch.valid && point_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Setup cycle then access cycle; the write lands on the access edge
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = PADDR_W'(idx) << 2;
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Hold until every predicted point has come back, then let the pipe settle
  task automatic drain_points();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Drive one beam beat, with a random gap ahead of it
  task automatic send_beam(input in_beat_t b);
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk);
      beam_ch.valid = 1'b0;
    end
    @(negedge clk);
    beam_ch.valid = 1'b1;
    beam_ch.data = b;
    do @(posedge clk); while (!beam_ch.ready);
  endtask

  task automatic release_beam();
    @(negedge clk);
    beam_ch.valid = 1'b0;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(65535) << $urandom_range(16);
      default: return $urandom;
    endcase
  endfunction

  // Mostly ordinary poses, sometimes extremes; ranges sometimes near the threshold
  function automatic in_beat_t random_beam();
    in_beat_t b;
    b.beam_index = 10'($urandom);
    b.left_range  = ($urandom_range(3) == 0) ? 16'($urandom_range(40)) : 16'($urandom);
    b.right_range = ($urandom_range(3) == 0) ? 16'($urandom_range(40)) : 16'($urandom);
    if ($urandom_range(3) == 0) begin
      b.pose_x = pick_word();
      b.pose_y = pick_word();
    end else begin
      b.pose_x = $signed($urandom_range(32'h00ff_ffff)) - 32'sh0080_0000;
      b.pose_y = $signed($urandom_range(32'h00ff_ffff)) - 32'sh0080_0000;
    end
    b.heading = ($urandom_range(7) == 0) ? ($urandom_range(3) << 30) + EIGHTH_TURN
                                         : $urandom;
    return b;
  endfunction

  function automatic in_beat_t make_beam(input logic [9:0] idx, input logic [15:0] lr,
                                         input logic [15:0] rr, input logic [31:0] px,
                                         input logic [31:0] py, input logic [31:0] hd);
    in_beat_t b;
    b.beam_index = idx;
    b.left_range = lr;
    b.right_range = rr;
    b.pose_x = px;
    b.pose_y = py;
    b.heading = hd;
    return b;
  endfunction

  task automatic set_phase_regs(input int phase);
    case (phase)
      0: begin
        reg_write(REG_MOUNT_FWD, 32'h0001_8000);
        reg_write(REG_MOUNT_SIDE, 32'h0000_4000);
        reg_write(REG_RIGHT_ROT, 32'h8000_0000);
      end
      1: begin
        reg_write(REG_MOUNT_FWD, 32'h7fff_ffff);
        reg_write(REG_MOUNT_SIDE, 32'h8000_0000);
        reg_write(REG_RIGHT_ROT, 32'hffff_ffff);
        reg_write(REG_BEAM_STEP, 32'hffff_ffff);
        reg_write(REG_RANGE_SCALE, 32'hffff_ffff);
        reg_write(REG_VALID_THR, 32'h0000_ffff);
      end
      2: begin
        reg_write(REG_MOUNT_FWD, 32'h8000_0000);
        reg_write(REG_MOUNT_SIDE, 32'h7fff_ffff);
        reg_write(REG_RIGHT_ROT, 32'h0);
        reg_write(REG_BEAM_STEP, 32'h0);
        reg_write(REG_RANGE_SCALE, 32'h0);
        reg_write(REG_VALID_THR, 32'h0);
      end
      default: begin
        reg_write(REG_MOUNT_FWD, $urandom_range(32'h0004_0000) - 32'h0002_0000);
        reg_write(REG_MOUNT_SIDE, $urandom_range(32'h0004_0000) - 32'h0002_0000);
        reg_write(REG_RIGHT_ROT, $urandom);
        reg_write(REG_BEAM_STEP, $urandom_range(32'h0100_0000));
        reg_write(REG_RANGE_SCALE, $urandom);
        reg_write(REG_VALID_THR, {16'hffff, 16'($urandom_range(200))});
        // unmapped slot: must not disturb anything
        reg_write(UNMAPPED_REG, $urandom);
      end
    endcase
  endtask

  task automatic directed_beams();
    send_beam(make_beam(10'd0, 16'd0, 16'd0, 32'h0, 32'h0, 32'h0));
    send_beam(make_beam(10'd1023, 16'hffff, 16'hffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0));
    send_beam(make_beam(10'd512, 16'hffff, 16'hffff, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000));
    send_beam(make_beam(10'd20, 16'd20, 16'd21, 32'h0, 32'h0, QUARTER_TURN));
    send_beam(make_beam(10'd21, 16'd21, 16'd20, 32'h0, 32'h0, 32'hc000_0000));
    send_beam(make_beam(10'd3, 16'd1000, 16'd1000, 32'h0, 32'h0, EIGHTH_TURN));
    send_beam(make_beam(10'd3, 16'd1000, 16'd1000, 32'h0, 32'h0, EIGHTH_TURN - 1));
    send_beam(make_beam(10'd5, 16'd5000, 16'd5000, 32'h7fff_0000, 32'h8001_0000,
                        32'hffff_ffff));
    send_beam(make_beam(10'h2aa, 16'haaaa, 16'h5555, 32'haaaa_aaaa, 32'h5555_5555,
                        32'h5555_5555));
    send_beam(make_beam(10'h155, 16'h5555, 16'haaaa, 32'h5555_5555, 32'haaaa_aaaa,
                        32'haaaa_aaaa));
    send_beam(make_beam(10'd200, 16'd0, 16'hffff, 32'h0001_0000, 32'hffff_0000,
                        32'h6000_0000));
    send_beam(make_beam(10'd1000, 16'hffff, 16'd0, 32'h0, 32'h0, 32'he000_0000));
    release_beam();
  endtask

  initial begin
    int phase;
    repeat (RST_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    for (phase = 0; phase < N_PHASES; phase++) begin
      set_phase_regs(phase);
      send_gap_pct = 0;
      sink_stall_pct = 0;
      // Directed corners under each of the edge settings
      if (phase < 3) directed_beams();
      for (int n = 0; n < BEAMS_PER_PHASE; n++) begin
        // open each phase with an unbroken stretch, then switch on idling (none in phase 3)
        if (n == 40) begin
          case (idle_mode_t'((phase + 1) % 4))
            IDLE_SENDER:   begin send_gap_pct = 52; sink_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_gap_pct = 0;  sink_stall_pct = 52; end
            IDLE_BOTH:     begin send_gap_pct = 31; sink_stall_pct = 31; end
            default:       begin send_gap_pct = 0;  sink_stall_pct = 0;  end
          endcase
        end
        // hold off once per phase until the pipe is empty
        if (n == BEAMS_PER_PHASE / 2) begin
          release_beam();
          while (pending != 0) @(posedge clk);
        end
        send_beam(random_beam());
      end
      release_beam();
      drain_points();
    end

    sink_stall_pct = 0;
    drain_points();
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+design
design/dlsw_pkg.sv
design/dlsw_if.sv
design/dlsw_cordic.sv
design/dlsw_lane.sv
design/dlsw_merge.sv
design/dual_laser_scan_to_world_points.sv
sim/dlsw_scoreboard.sv
sim/tb_top.sv
